// File: sv/ucal_pkg.sv
// ----------------------------------------------------------------------------
// ucal_pkg
// Shared types, constants and table functions for the epoch to calendar
// converter.
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned PROD_W  = 2 * EPOCH_W;
  localparam int unsigned OPND_W  = 16;
  localparam int unsigned SUBT_W  = 9;
  localparam int unsigned REM_W   = 6;

  typedef logic [EPOCH_W-1:0] epoch_t;
  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [SUBT_W-1:0] subt_t;
  typedef logic [11:0]       year_t;
  typedef logic [3:0]        month_t;
  typedef logic [1:0]        div_idx_t;

  localparam year_t    BASE_YEAR    = 12'd1970;
  localparam year_t    CENTURY_YEAR = 12'd2100;
  localparam subt_t    DAYS_LEAP    = 9'd366;
  localparam subt_t    DAYS_COMMON  = 9'd365;
  localparam month_t   LAST_MONTH   = 4'd11;
  localparam epoch_t   WDAY_OFFSET  = 32'd4;

  localparam div_idx_t DIV_SEC  = 2'd0;
  localparam div_idx_t DIV_MIN  = 2'd1;
  localparam div_idx_t DIV_HOUR = 2'd2;
  localparam div_idx_t DIV_WDAY = 2'd3;

  // reciprocal shifts, exact over the input range of each pass
  localparam int unsigned SHIFT_60 = 37;
  localparam int unsigned SHIFT_24 = 36;
  localparam int unsigned SHIFT_7  = 34;

  // divisor of each division pass
  function automatic subt_t div_const(input div_idx_t idx);
    subt_t d;
    unique case (idx)
      DIV_SEC:  d = 9'd60;
      DIV_MIN:  d = 9'd60;
      DIV_HOUR: d = 9'd24;
      DIV_WDAY: d = 9'd7;
      default:  d = 9'd60;
    endcase
    return d;
  endfunction

  // rounded-up reciprocal of each divisor
  function automatic epoch_t div_magic(input div_idx_t idx);
    epoch_t m;
    unique case (idx)
      DIV_SEC:  m = 32'h8888_8889;
      DIV_MIN:  m = 32'h8888_8889;
      DIV_HOUR: m = 32'hAAAA_AAAB;
      DIV_WDAY: m = 32'h9249_2493;
      default:  m = 32'h8888_8889;
    endcase
    return m;
  endfunction

  // only non-leap century year between 1970 and 2106 is 2100
  function automatic logic is_leap(input year_t y);
    return (y[1:0] == 2'b00) && (y != CENTURY_YEAR);
  endfunction

  function automatic subt_t month_len(input month_t m, input logic leap);
    subt_t len;
    case (m) inside
      4'd1:                         len = leap ? 9'd29 : 9'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      len = 9'd30;
      default:                      len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

// File: sv/ucal_cmpsub.sv
// ----------------------------------------------------------------------------
// ucal_cmpsub
// Shared compare and subtract unit used by the year and month walks.
// ----------------------------------------------------------------------------
module ucal_cmpsub (
  input  ucal_pkg::opnd_t a,
  input  ucal_pkg::subt_t b,
  output logic            geq,
  output ucal_pkg::opnd_t diff
);
  import ucal_pkg::*;

  logic [OPND_W:0] wide;

  assign wide = {1'b0, a} - {{(OPND_W-SUBT_W+1){1'b0}}, b};
  assign geq  = ~wide[OPND_W];
  assign diff = wide[OPND_W-1:0];

endmodule

// File: sv/unix_time_to_calendar.sv
// ----------------------------------------------------------------------------
// unix_time_to_calendar
// Converts unsigned seconds since 1970-01-01 00:00:00 into second, minute,
// hour, weekday, year, month and day of month.
// ----------------------------------------------------------------------------
// sequence: four reciprocal-multiply divisions, each a multiply state then a
// quotient state, then a year walk and a month walk, one year or month per step
// one item at a time; the next item is taken the cycle after the result is
// loaded into the output register
// a result held by out_stall keeps the block busy; walks share one 16-bit unit
// synchronous active-low reset clears the sequencer and output valid
// ----------------------------------------------------------------------------
module unix_time_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day
);
  import ucal_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_YEAR = 5'b01000,
    S_MON  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [EPOCH_W-1:0]   q_r, q_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  div_idx_t             idx_r, idx_nxt;
  opnd_t                day_r, day_nxt;
  year_t                yr_r, yr_nxt;
  month_t               mon_r, mon_nxt;
  logic [5:0]           sec_r, sec_nxt;
  logic [5:0]           min_r, min_nxt;
  logic [4:0]           hr_r, hr_nxt;
  logic [2:0]           wday_r, wday_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [5:0]           out_second_r, out_second_nxt;
  logic [5:0]           out_minute_r, out_minute_nxt;
  logic [4:0]           out_hour_r, out_hour_nxt;
  logic [2:0]           out_weekday_r, out_weekday_nxt;
  year_t                out_year_r, out_year_nxt;
  month_t               out_month_r, out_month_nxt;
  logic [4:0]           out_day_r, out_day_nxt;

  opnd_t                unit_a;
  subt_t                unit_b;
  logic                 unit_geq;
  opnd_t                unit_diff;

  subt_t                div_sel;
  epoch_t               magic;
  logic [EPOCH_W-1:0]   quo;
  logic [2*REM_W-1:0]   back_mul;
  logic [REM_W-1:0]     rem_step;
  logic                 leap;
  logic                 mon_done;
  logic                 out_free;

  ucal_cmpsub u_cmpsub (
    .a    (unit_a),
    .b    (unit_b),
    .geq  (unit_geq),
    .diff (unit_diff)
  );

  assign leap     = is_leap(yr_r);
  assign div_sel  = div_const(idx_r);
  assign magic    = div_magic(idx_r);
  assign back_mul = {{REM_W{1'b0}}, quo[REM_W-1:0]} * {{REM_W{1'b0}}, div_sel[REM_W-1:0]};
  assign rem_step = q_r[REM_W-1:0] - back_mul[REM_W-1:0];
  assign mon_done = (mon_r == LAST_MONTH) || !unit_geq;
  assign out_free = !out_valid_r || !out_stall;
  assign unit_a   = day_r;

  // quotient from the registered reciprocal product
  always_comb begin
    unique case (idx_r)
      DIV_SEC:  quo = EPOCH_W'(prod_r >> SHIFT_60);
      DIV_MIN:  quo = EPOCH_W'(prod_r >> SHIFT_60);
      DIV_HOUR: quo = EPOCH_W'(prod_r >> SHIFT_24);
      DIV_WDAY: quo = EPOCH_W'(prod_r >> SHIFT_7);
      default:  quo = EPOCH_W'(prod_r >> SHIFT_60);
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    unique case (state_r)
      S_YEAR:  unit_b = leap ? DAYS_LEAP : DAYS_COMMON;
      S_MON:   unit_b = month_len(mon_r, leap);
      default: unit_b = DAYS_COMMON;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    q_nxt           = q_r;
    prod_nxt        = prod_r;
    idx_nxt         = idx_r;
    day_nxt         = day_r;
    yr_nxt          = yr_r;
    mon_nxt         = mon_r;
    sec_nxt         = sec_r;
    min_nxt         = min_r;
    hr_nxt          = hr_r;
    wday_nxt        = wday_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_second_nxt  = out_second_r;
    out_minute_nxt  = out_minute_r;
    out_hour_nxt    = out_hour_r;
    out_weekday_nxt = out_weekday_r;
    out_year_nxt    = out_year_r;
    out_month_nxt   = out_month_r;
    out_day_nxt     = out_day_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_nxt     = in_epoch_seconds;
          idx_nxt   = DIV_SEC;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {{EPOCH_W{1'b0}}, q_r} * {{EPOCH_W{1'b0}}, magic};
        state_nxt = S_DIV;
      end
      S_DIV: begin
        q_nxt     = quo;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_MUL;
        unique case (idx_r)
          DIV_SEC: begin
            sec_nxt = rem_step;
          end
          DIV_MIN: begin
            min_nxt = rem_step;
          end
          DIV_HOUR: begin
            // day count below 2^16
            hr_nxt  = rem_step[4:0];
            day_nxt = quo[OPND_W-1:0];
            q_nxt   = quo + WDAY_OFFSET;
          end
          DIV_WDAY: begin
            wday_nxt  = rem_step[2:0] + 3'd1;
            yr_nxt    = BASE_YEAR;
            state_nxt = S_YEAR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_YEAR: begin
        if (unit_geq) begin
          day_nxt = unit_diff;
          yr_nxt  = yr_r + 1'b1;
        end else begin
          mon_nxt   = '0;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if (!mon_done) begin
          day_nxt = unit_diff;
          mon_nxt = mon_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_second_nxt  = sec_r;
          out_minute_nxt  = min_r;
          out_hour_nxt    = hr_r;
          out_weekday_nxt = wday_r;
          out_year_nxt    = yr_r;
          out_month_nxt   = mon_r + 1'b1;
          out_day_nxt     = day_r[4:0] + 5'd1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    prod_r        <= prod_nxt;
    idx_r         <= idx_nxt;
    day_r         <= day_nxt;
    yr_r          <= yr_nxt;
    mon_r         <= mon_nxt;
    sec_r         <= sec_nxt;
    min_r         <= min_nxt;
    hr_r          <= hr_nxt;
    wday_r        <= wday_nxt;
    out_second_r  <= out_second_nxt;
    out_minute_r  <= out_minute_nxt;
    out_hour_r    <= out_hour_nxt;
    out_weekday_r <= out_weekday_nxt;
    out_year_r    <= out_year_nxt;
    out_month_r   <= out_month_nxt;
    out_day_r     <= out_day_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_second  = out_second_r;
  assign out_minute  = out_minute_r;
  assign out_hour    = out_hour_r;
  assign out_weekday = out_weekday_r;
  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({3'b000, rem_step} < div_sel))
    else $error("division remainder not below divisor");

  a_year_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR) |-> (yr_r <= 12'd2106))
    else $error("year walk past 2106");

  a_result_from_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_MON))
    else $error("result loaded outside month walk");

  a_month_day_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MON) |-> (day_r < 16'd31 || !mon_done || (mon_r != LAST_MONTH) ||
                            !unit_geq))
    else $error("day of month out of range");

endmodule
